// ----- rtl/core/lrkc_pkg.sv -----
// Shared types and constants for the loop recorder key controller.
// Used by the front decoder, the command queue, the execution unit and the top level.
// Depends on nothing.
package lrkc_pkg;

  // Looper modes as reported on the result item.
  typedef enum logic [1:0] {
    MODE_REST = 2'd0,
    MODE_REC  = 2'd1,
    MODE_PLAY = 2'd2,
    MODE_OVER = 2'd3
  } mode_e;

  // Classified event kind handed from the front to the back.
  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_PRESS   = 2'd1,
    EVT_RELEASE = 2'd2
  } evt_e;

  // Raw edge codes in the low bits of the event byte.
  localparam logic [1:0] EDGE_PRESS   = 2'd2;
  localparam logic [1:0] EDGE_RELEASE = 2'd3;

  // Key codes and note codes.
  localparam logic [3:0] KEY_FIRST_CTRL = 4'd12;
  localparam logic [3:0] KEY_REC        = 4'd12;
  localparam logic [3:0] KEY_RUN        = 4'd13;
  localparam logic [3:0] KEY_HALT       = 4'd14;
  localparam logic [3:0] KEY_INSTR      = 4'd15;
  localparam logic [3:0] KEY_WAVE_LAST  = 4'd4;
  localparam logic [3:0] NOTE_OFF       = 4'd12;
  localparam logic [4:0] HELD_NONE      = 5'd16;

  // Stream widths.
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 96;

  // Command queue depth between front and back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  // One classified item in flight from front to back.
  typedef struct packed {
    evt_e        kind;
    logic [3:0]  key;
    logic [31:0] time_ms;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [31:0] loop_duration;
    logic [2:0]  layers_held;
    logic [31:0] write_delta;
    logic [3:0]  write_note;
    logic [7:0]  write_index;
    logic [1:0]  write_layer;
    logic        write_valid;
    logic [3:0]  note;
    logic [2:0]  waveform;
    logic        instr_select;
    mode_e       mode;
  } res_t;

endpackage

// ----- rtl/core/loop_recorder_key_controller.sv -----
// Top level of the loop recorder key controller: config register, front, queue, back.
// Depends on lrkc_pkg, lrkc_front, lrkc_queue and lrkc_exec.
//
//  Channel  Dir  Signals                   Contents
//  s_axis   in   tvalid/tready/tdata[39:0] event_byte[7:0], time_ms[39:8]
//  m_axis   out  tvalid/tready/tdata[95:0] status and recorded write, see port comment
//               tuser[0]                  write_valid
//  cfg      in   cfg_we_i/cfg_wdata_i[1:0] active_loop_index
//
// Each item passes the front decode in its accept cycle and is written into the two-entry queue;
// the execution unit pops it from there and registers its update in the result register: one item
// per cycle sustained while the output takes results.
// Reset is asynchronous and clears all bookkeeping at once; no sweep follows.
// A stalled output holds the result register; the queue absorbs up to two more items.
module loop_recorder_key_controller #(
  parameter int unsigned LAYERS           = 4,
  parameter int unsigned EVENTS_PER_LAYER = 256,
  parameter int unsigned LOOPS            = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input items.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // event_byte[7:0], time_ms[39:8]
  input  logic [lrkc_pkg::InDataW-1:0]      s_axis_tdata,
  // Result items.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_mode[1:0], out_instr_select[2], out_waveform[5:3], out_note[9:6],
  // write_layer[11:10], write_index[19:12], write_note[23:20], write_delta[55:24],
  // layers held[58:56], out_loop_duration[90:59], zero[95:91]
  output logic [lrkc_pkg::OutDataW-1:0]     m_axis_tdata,
  // write_valid[0]
  output logic                              m_axis_tuser,
  // Configuration write.
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_wdata_i
);
  import lrkc_pkg::*;

  logic [1:0] active_loop_q;
  logic       q_full, q_push, q_pop, q_valid;
  cmd_t       front_cmd, q_head;
  res_t       res;

  // Active loop register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_loop_q <= '0;
    end else if (cfg_we_i) begin
      active_loop_q <= cfg_wdata_i;
    end
  end

  lrkc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .cmd_o         (front_cmd)
  );

  lrkc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  lrkc_exec #(
    .LAYERS           (LAYERS),
    .EVENTS_PER_LAYER (EVENTS_PER_LAYER),
    .LOOPS            (LOOPS)
  ) u_exec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .active_loop_i (active_loop_q),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_head),
    .cmd_pop_o     (q_pop),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_o         (res)
  );

  // Pack the result item onto the output stream.
  assign m_axis_tuser = res.write_valid;
  assign m_axis_tdata = {5'd0, res.loop_duration, res.layers_held, res.write_delta,
                         res.write_note, res.write_index, res.write_layer, res.note,
                         res.waveform, res.instr_select, res.mode};

endmodule

// ----- rtl/core/lrkc_front.sv -----
// Front stage: takes raw keypad items, decodes edge and gapped key index, classifies them.
// Depends on lrkc_pkg; feeds lrkc_queue.
module lrkc_front (
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lrkc_pkg::InDataW-1:0]      s_axis_tdata,
  input  logic                              q_full_i,
  output logic                              push_o,
  output lrkc_pkg::cmd_t                    cmd_o
);
  import lrkc_pkg::*;

  logic [7:0] event_byte;
  logic [1:0] edge_code;
  logic [5:0] slot;
  logic [4:0] key_full;

  assign event_byte = s_axis_tdata[7:0];
  assign edge_code  = event_byte[1:0];
  assign slot       = event_byte[7:2];

  // Gapped slot to key: groups of eight slots hold four keys each.
  assign key_full = {slot[5:3], slot[1:0]};

  // Accept whenever the queue has room.
  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  // Classify the item; bad keys and other edges still pass on to report status.
  always_comb begin
    cmd_o.key     = key_full[3:0];
    cmd_o.time_ms = s_axis_tdata[39:8];
    cmd_o.kind    = EVT_NONE;
    if (!key_full[4]) begin
      if (edge_code == EDGE_PRESS) begin
        cmd_o.kind = EVT_PRESS;
      end else if (edge_code == EDGE_RELEASE) begin
        cmd_o.kind = EVT_RELEASE;
      end
    end
  end

endmodule

// ----- rtl/core/lrkc_queue.sv -----
// Short command queue that decouples the front decoder from the execution unit.
// Depends on lrkc_pkg for the entry type and depth.
module lrkc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lrkc_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output lrkc_pkg::cmd_t head_o
);
  import lrkc_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/lrkc_exec.sv -----
// Back stage: looper mode machine, layer bookkeeping and the registered result item.
// Depends on lrkc_pkg; takes commands from lrkc_queue.
module lrkc_exec #(
  parameter int unsigned LAYERS           = 4,
  parameter int unsigned EVENTS_PER_LAYER = 256,
  parameter int unsigned LOOPS            = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     active_loop_i,
  input  logic           cmd_valid_i,
  input  lrkc_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output lrkc_pkg::res_t res_o
);
  import lrkc_pkg::*;

  localparam int unsigned LW  = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int unsigned LPW = (LOOPS > 1) ? $clog2(LOOPS) : 1;
  localparam int unsigned CW  = $clog2(EVENTS_PER_LAYER + 1);
  localparam int unsigned LCW = $clog2(LAYERS + 1);

  // Mode machine and per-item state.
  mode_e       mode_q, mode_d;
  logic        instr_q, instr_d;
  logic [2:0]  wave_q, wave_d;
  logic [3:0]  note_q, note_d;
  logic [4:0]  held_q, held_d;
  logic [31:0] rec_start_q, rec_start_d;
  logic [31:0] last_q, last_d;
  logic [LW-1:0] tl_q, tl_d;

  // Layer bookkeeping per loop.
  logic [CW-1:0]  cnt_q [LOOPS][LAYERS];
  logic [LCW-1:0] llc_q [LOOPS];
  logic [31:0]    dur_q [LOOPS];

  // Result register.
  res_t res_q, res_d;
  logic res_valid_q;

  // Actions chosen for this item.
  logic do_close, do_begin, begin_zero, do_rec, clr_loop;
  logic [3:0] rec_note;

  logic          pop;
  logic [4:0]    lp_w;
  logic [LPW-1:0] lp;
  logic [CW-1:0] n;
  logic [CW+7:0] n_ext;
  logic [LW+1:0] tl_ext;
  logic [LCW+2:0] lc_ext;
  logic [LCW-1:0] llc_cur, llc_after, tl_plus1;
  logic [31:0]   dur_after;
  logic [LW-1:0] next_layer, begin_tl;
  logic          wr_ok;
  logic [31:0]   t;

  // The result slot is free when empty or being taken this cycle.
  assign pop         = cmd_valid_i && (!res_valid_q || res_ready_i);
  assign cmd_pop_o   = pop;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign t           = cmd_i.time_ms;

  // Active loop index reduced into range by repeated subtraction.
  always_comb begin
    lp_w = {3'b000, active_loop_i};
    for (int k = 0; k < 3; k++) begin
      if (lp_w >= 5'(LOOPS)) begin
        lp_w = lp_w - 5'(LOOPS);
      end
    end
  end
  assign lp = lp_w[LPW-1:0];

  assign n        = cnt_q[lp][tl_q];
  assign llc_cur  = llc_q[lp];
  assign tl_plus1 = LCW'(tl_q) + LCW'(1);

  // Next state: mode machine and the actions one item calls for.
  always_comb begin
    mode_d     = mode_q;
    instr_d    = instr_q;
    wave_d     = wave_q;
    note_d     = note_q;
    held_d     = held_q;
    do_close   = 1'b0;
    do_begin   = 1'b0;
    begin_zero = 1'b0;
    do_rec     = 1'b0;
    clr_loop   = 1'b0;
    rec_note   = NOTE_OFF;
    if (pop) begin
      case (cmd_i.kind)
        EVT_PRESS: begin
          if (instr_q) begin
            if (cmd_i.key <= KEY_WAVE_LAST) begin
              wave_d = cmd_i.key[2:0];
            end else if (cmd_i.key == KEY_INSTR) begin
              instr_d = 1'b0;
            end
          end else if (cmd_i.key < KEY_FIRST_CTRL) begin
            note_d   = cmd_i.key;
            held_d   = {1'b0, cmd_i.key};
            do_rec   = (mode_q == MODE_REC) || (mode_q == MODE_OVER);
            rec_note = cmd_i.key;
          end else begin
            case (cmd_i.key)
              KEY_REC: begin
                do_begin = 1'b1;
                case (mode_q)
                  MODE_REST: begin
                    clr_loop   = 1'b1;
                    begin_zero = 1'b1;
                    mode_d     = MODE_REC;
                  end
                  MODE_PLAY: begin
                    mode_d = MODE_OVER;
                  end
                  default: begin
                    do_close = 1'b1;
                  end
                endcase
              end
              KEY_RUN: begin
                case (mode_q)
                  MODE_REST, MODE_PLAY: begin
                    mode_d = MODE_PLAY;
                  end
                  MODE_OVER: begin
                    do_close = 1'b1;
                    mode_d   = MODE_PLAY;
                  end
                  default: begin
                  end
                endcase
              end
              KEY_HALT: begin
                do_close = (mode_q == MODE_REC) || (mode_q == MODE_OVER);
                mode_d   = MODE_REST;
                note_d   = NOTE_OFF;
                instr_d  = 1'b0;
                held_d   = HELD_NONE;
              end
              default: begin
                if (mode_q == MODE_REST) begin
                  instr_d = 1'b1;
                end
              end
            endcase
          end
        end
        EVT_RELEASE: begin
          if ((cmd_i.key < KEY_FIRST_CTRL) && ({1'b0, cmd_i.key} == held_q)) begin
            note_d   = NOTE_OFF;
            held_d   = HELD_NONE;
            do_rec   = (mode_q == MODE_REC) || (mode_q == MODE_OVER);
            rec_note = NOTE_OFF;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath: layer close, new layer start, event record and the result item.
  always_comb begin
    llc_after = llc_cur;
    dur_after = dur_q[lp];
    if (clr_loop) begin
      llc_after = '0;
      dur_after = '0;
    end else if (do_close) begin
      if (tl_q == '0) begin
        dur_after = t - rec_start_q;
      end
      if ((n != '0) && (tl_plus1 > llc_cur)) begin
        llc_after = tl_plus1;
      end
    end
    next_layer = (llc_after >= LCW'(LAYERS)) ? LW'(LAYERS - 1) : LW'(llc_after);
    begin_tl   = begin_zero ? '0 : next_layer;

    rec_start_d = rec_start_q;
    last_d      = last_q;
    tl_d        = tl_q;
    if (do_begin) begin
      rec_start_d = t;
      last_d      = t;
      tl_d        = begin_tl;
    end else if (do_rec) begin
      last_d = t;
    end
    wr_ok = do_rec && (n < CW'(EVENTS_PER_LAYER));

    n_ext  = {8'd0, n};
    tl_ext = {2'd0, tl_q};
    lc_ext = {3'd0, llc_after};

    res_d               = '0;
    res_d.mode          = mode_d;
    res_d.instr_select  = instr_d;
    res_d.waveform      = wave_d;
    res_d.note          = note_d;
    res_d.layers_held   = lc_ext[2:0];
    res_d.loop_duration = dur_after;
    if (wr_ok) begin
      res_d.write_valid = 1'b1;
      res_d.write_layer = tl_ext[1:0];
      res_d.write_index = n_ext[7:0];
      res_d.write_note  = rec_note;
      res_d.write_delta = t - last_q;
    end
  end

  // Control and mode state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_REST;
      instr_q     <= 1'b0;
      wave_q      <= '0;
      note_q      <= NOTE_OFF;
      held_q      <= HELD_NONE;
      rec_start_q <= '0;
      last_q      <= '0;
      tl_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      instr_q     <= instr_d;
      wave_q      <= wave_d;
      note_q      <= note_d;
      held_q      <= held_d;
      rec_start_q <= rec_start_d;
      last_q      <= last_d;
      tl_q        <= tl_d;
      if (pop) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Per-loop layer counts, durations and per-layer event counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LOOPS; i++) begin
        llc_q[i] <= '0;
        dur_q[i] <= '0;
        for (int j = 0; j < LAYERS; j++) begin
          cnt_q[i][j] <= '0;
        end
      end
    end else if (pop) begin
      llc_q[lp] <= llc_after;
      dur_q[lp] <= dur_after;
      if (clr_loop) begin
        for (int j = 0; j < LAYERS; j++) begin
          cnt_q[lp][j] <= '0;
        end
      end else if (do_begin) begin
        cnt_q[lp][begin_tl] <= '0;
      end else if (wr_ok) begin
        cnt_q[lp][tl_q] <= n + CW'(1);
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

endmodule
